[design/hsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, widths and tables for the Hamming single-error decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

   localparam int CODE_W        = 63;
   localparam int DATA_W        = 57;
   localparam int SYN_W         = 6;
   localparam int LEN_W         = 7;
   localparam int DBITS_W       = 6;
   localparam int CBITS_W       = 3;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 6;
   localparam int REQ_TDATA_W   = 64;
   localparam int RSP_TDATA_W   = 72;
   localparam int MAX_CODE_BITS = 63;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BITS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_BITS = 1'b1;

   localparam logic [DBITS_W-1:0] DATA_BITS_RST  = 6'd57;
   localparam logic [CBITS_W-1:0] CHECK_BITS_RST = 3'd6;

   typedef logic [DATA_W-1:0][SYN_W-1:0] data_pos_type;

   typedef struct packed {
      logic [DBITS_W-1:0] data_bits;
      logic [CBITS_W-1:0] check_bits;
   } cfg_type;

   typedef struct packed {
      logic                 uncorrectable;
      logic [SYN_W-1:0]     syndrome;
      logic                 error_found;
      logic [DATA_W-1:0]    data_out;
   } result_type;

   // Bit index in the codeword of each data bit, lowest data bit first
   function automatic data_pos_type data_positions();
      data_pos_type pos;
      int           j;
      pos = '0;
      j   = 0;
      for (int p = 0; p < CODE_W; p++) begin
         if ((((p + 1) & p) != 0) && (j < DATA_W)) begin
            pos[j] = SYN_W'(p);
            j++;
         end
      end
      return pos;
   endfunction

   localparam data_pos_type DATA_POS = data_positions();

endpackage
`default_nettype wire

[design/hsd_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_csr
// Configuration registers: message length and parity bit count.
// ----------------------------------------------------------------------------
module hsd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [hsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [hsd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output hsd_pkg::cfg_type                     cfg
);
   import hsd_pkg::*;

   logic [DBITS_W-1:0] data_bits_ff;
   logic [CBITS_W-1:0] check_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff  <= DATA_BITS_RST;
         check_bits_ff <= CHECK_BITS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_BITS: begin
               data_bits_ff <= csr_wdata[DBITS_W-1:0];
            end
            CSR_CHECK_BITS: begin
               check_bits_ff <= csr_wdata[CBITS_W-1:0];
            end
            default: begin
               data_bits_ff <= data_bits_ff;
            end
         endcase
      end
   end

   assign cfg.data_bits  = data_bits_ff;
   assign cfg.check_bits = check_bits_ff;

endmodule
`default_nettype wire

[design/hsd_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_decode
// Syndrome, single-bit correction and data extraction for one codeword.
// ----------------------------------------------------------------------------
module hsd_decode #(
   parameter int MAX_CODE_BITS = hsd_pkg::MAX_CODE_BITS
) (
   input  wire logic [hsd_pkg::CODE_W-1:0]  codeword,
   input  hsd_pkg::cfg_type                 cfg,
   output hsd_pkg::result_type              result
);
   import hsd_pkg::*;

   logic [LEN_W-1:0]  len_sum;
   logic [SYN_W-1:0]  len;
   logic [CODE_W-1:0] word;
   logic [CODE_W-1:0] fixed;
   logic [SYN_W-1:0]  syn;
   logic              err;
   logic              bad;
   logic [DATA_W-1:0] data;

   always_comb begin
      len_sum = LEN_W'(cfg.data_bits) + LEN_W'(cfg.check_bits);
      if (len_sum > LEN_W'(MAX_CODE_BITS)) begin
         len = SYN_W'(MAX_CODE_BITS);
      end else begin
         len = len_sum[SYN_W-1:0];
      end
   end

   always_comb begin
      syn = '0;
      for (int p = 0; p < CODE_W; p++) begin
         word[p] = codeword[p] & (SYN_W'(p) < len);
      end
      for (int p = 0; p < CODE_W; p++) begin
         for (int k = 0; k < SYN_W; k++) begin
            if (((p + 1) & (1 << k)) != 0) begin
               syn[k] = syn[k] ^ word[p];
            end
         end
      end
   end

   assign err = (syn != '0);
   assign bad = err && (syn > len);

   always_comb begin
      for (int p = 0; p < CODE_W; p++) begin
         fixed[p] = word[p] ^ (err && !bad && (syn == SYN_W'(p + 1)));
      end
   end

   always_comb begin
      for (int i = 0; i < DATA_W; i++) begin
         data[i] = fixed[DATA_POS[i]];
      end
   end

   assign result.data_out      = data;
   assign result.error_found   = err;
   assign result.syndrome      = syn;
   assign result.uncorrectable = bad;

endmodule
`default_nettype wire

[design/hamming_sec_decoder_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_sec_decoder_unit
// Hamming single-error-correcting decoder with stream ports.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// req_      in   tdata: codeword[62:0], zero pad [63]
// rsp_      out  tdata: data_out[56:0], error_found[57], syndrome[63:58],
//                       uncorrectable[64], zero pad [71:65]
// csr_      in   index 0: data_bits, index 1: check_bits
//
// One request per cycle while the result is not stalled; each accepted request
// passes through the input register, then the parity trees and correction mux,
// then the result register before it is offered.
// Synchronous reset empties both stages and loads the default length.
// A stalled result holds in the output register while one more request
// waits in the input register.
// ----------------------------------------------------------------------------
module hamming_sec_decoder_unit #(
   parameter int MAX_CODE_BITS = hsd_pkg::MAX_CODE_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [hsd_pkg::REQ_TDATA_W-1:0]   req_tdata,  // codeword
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [hsd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // data_out, error_found,
                                                              // syndrome, uncorrectable
   input  wire logic                              csr_we,
   input  wire logic [hsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hsd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hsd_pkg::*;

   cfg_type           cfg;
   result_type        result;
   logic              in_valid_ff;
   logic [CODE_W-1:0] codeword_ff;
   logic              out_valid_ff;
   result_type        result_ff;
   logic              out_free;
   logic              in_adv;

   hsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hsd_decode #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_decode (
      .codeword (codeword_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign in_adv     = !in_valid_ff || out_free;
   assign req_tready = in_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_tvalid) begin
         codeword_ff <= req_tdata[CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid_ff) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - $bits(result_type))'(0), result_ff};

endmodule
`default_nettype wire

[design/hsd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks for the Hamming decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hsd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [hsd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [hsd_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import hsd_pkg::*;

   logic             err;
   logic             bad;
   logic [SYN_W-1:0] syn;

   assign err = rsp_tdata[DATA_W];
   assign syn = rsp_tdata[DATA_W+SYN_W:DATA_W+1];
   assign bad = rsp_tdata[DATA_W+SYN_W+1];

   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_err_syn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (err == (syn != '0)))
      else $error("error flag disagrees with syndrome");

   a_bad_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && bad) |-> err)
      else $error("uncorrectable without error");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   a_req_pass: assert property (@(posedge clock) disable iff (reset)
      ($past(req_tvalid && req_tready, 2) && !$past(reset, 1) && !$past(reset, 2)
       && $past(rsp_tready) && $past(!rsp_tvalid || rsp_tready, 2)
       && $past(req_tdata != '0, 2) && !$past(rsp_tvalid && !rsp_tready))
      |-> rsp_tvalid)
      else $error("accepted request did not reach output");

endmodule

bind hamming_sec_decoder_unit hsd_checker u_hsd_checker (.*);
`default_nettype wire
